/* hw/rtl/dstf_pkg.sv */
// dstf_pkg: types and constants shared by the deadline-sortable task fifo
// used by the channel interfaces, the controller, the datapath and the checker
`timescale 1ns / 1ps
`default_nettype none

package dstf_pkg;

  localparam int unsigned FUNC_W = 2;
  localparam int unsigned ID_W   = 16;
  localparam int unsigned DL_W   = 32;
  localparam int unsigned ST_W   = 2;
  localparam int unsigned OCC_W  = 5;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ENQ  = 2'd0,
    FUNC_DEQ  = 2'd1,
    FUNC_SORT = 2'd2
  } func_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // read port address select
  typedef enum logic [1:0] {
    RD_HEAD   = 2'd0,
    RD_I      = 2'd1,
    RD_I_M1   = 2'd2,
    RD_POS_M2 = 2'd3
  } rd_sel_e;

  // write port source select
  typedef enum logic [1:0] {
    WR_NONE      = 2'd0,
    WR_TAIL      = 2'd1,
    WR_POS_RDATA = 2'd2,
    WR_POS_HELD  = 2'd3
  } wr_sel_e;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [DL_W-1:0] dl;
  } entry_t;

  typedef struct packed {
    logic    push;
    logic    pop;
    rd_sel_e rd_sel;
    wr_sel_e wr_sel;
    logic    hold_load;
    logic    pos_dec;
    logic    i_init;
    logic    i_inc;
    logic    res_load;
    logic    res_data;
    status_e res_status;
  } cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic cnt_full;
    logic cnt_small;
    logic dl_gt;
    logic pos_one;
    logic i_last;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

/* hw/rtl/dstf_if.sv */
// dstf_req_if and dstf_rsp_if: valid/ready channels of the task fifo
// depends on dstf_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface dstf_req_if;
  import dstf_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [ID_W-1:0]   task_id;
  logic [DL_W-1:0]   deadline;

  modport source (output valid, func, task_id, deadline, input ready);
  modport sink   (input valid, func, task_id, deadline, output ready);
endinterface

interface dstf_rsp_if;
  import dstf_pkg::*;

  logic             valid;
  logic             ready;
  logic [ID_W-1:0]  out_task_id;
  logic [DL_W-1:0]  out_deadline;
  logic [ST_W-1:0]  status;
  logic [OCC_W-1:0] occupancy;

  modport source (output valid, out_task_id, out_deadline, status, occupancy, input ready);
  modport sink   (input valid, out_task_id, out_deadline, status, occupancy, output ready);
endinterface

`default_nettype wire

/* hw/rtl/dstf_ctrl.sv */
// dstf_ctrl: operation sequencer of the task fifo, drives datapath commands
// depends on dstf_pkg
`timescale 1ns / 1ps
`default_nettype none

module dstf_ctrl (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       req_valid_i,
  input  wire logic [dstf_pkg::FUNC_W-1:0] req_func_i,
  output logic                            req_ready_o,
  input  wire dstf_pkg::stat_t            stat_i,
  output dstf_pkg::cmd_t                  cmd_o
);
  import dstf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEQ,
    S_FETCH,
    S_HOLD,
    S_CMP,
    S_PLACE,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign req_ready_o = (state_q == S_IDLE) && stat_i.out_free;
  assign accept      = req_valid_i && req_ready_o;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (req_func_i)
            FUNC_ENQ: begin
              cmd_o.res_load = 1'b1;
              if (stat_i.cnt_full) begin
                cmd_o.res_status = ST_FULL;
              end else begin
                cmd_o.push   = 1'b1;
                cmd_o.wr_sel = WR_TAIL;
              end
            end
            FUNC_DEQ: begin
              if (stat_i.cnt_zero) begin
                cmd_o.res_load   = 1'b1;
                cmd_o.res_status = ST_EMPTY;
              end else begin
                cmd_o.pop    = 1'b1;
                cmd_o.rd_sel = RD_HEAD;
                state_d      = S_DEQ;
              end
            end
            FUNC_SORT: begin
              if (stat_i.cnt_small) begin
                cmd_o.res_load = 1'b1;
              end else begin
                cmd_o.i_init = 1'b1;
                state_d      = S_FETCH;
              end
            end
            default: begin
              cmd_o.res_load = 1'b1;
            end
          endcase
        end
      end
      S_DEQ: begin
        cmd_o.res_load = 1'b1;
        cmd_o.res_data = 1'b1;
        state_d        = S_IDLE;
      end
      S_FETCH: begin
        cmd_o.rd_sel = RD_I;
        state_d      = S_HOLD;
      end
      S_HOLD: begin
        cmd_o.hold_load = 1'b1;
        cmd_o.rd_sel    = RD_I_M1;
        state_d         = S_CMP;
      end
      S_CMP: begin
        if (stat_i.dl_gt) begin
          // shift the larger entry up one slot and look one further down
          cmd_o.wr_sel  = WR_POS_RDATA;
          cmd_o.pos_dec = 1'b1;
          cmd_o.rd_sel  = RD_POS_M2;
          if (stat_i.pos_one) begin
            state_d = S_PLACE;
          end
        end else begin
          cmd_o.wr_sel = WR_POS_HELD;
          cmd_o.i_inc  = 1'b1;
          state_d      = stat_i.i_last ? S_DONE : S_FETCH;
        end
      end
      S_PLACE: begin
        cmd_o.wr_sel = WR_POS_HELD;
        cmd_o.i_inc  = 1'b1;
        state_d      = stat_i.i_last ? S_DONE : S_FETCH;
      end
      S_DONE: begin
        cmd_o.res_load = 1'b1;
        state_d        = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/dstf_datapath.sv */
// dstf_datapath: entry memory, head/tail/count pointers, sort registers
// and the result register of the task fifo; depends on dstf_pkg
`timescale 1ns / 1ps
`default_nettype none

module dstf_datapath #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire dstf_pkg::cmd_t             cmd_i,
  output dstf_pkg::stat_t                 stat_o,
  input  wire logic [dstf_pkg::ID_W-1:0]  enq_id_i,
  input  wire logic [dstf_pkg::DL_W-1:0]  enq_dl_i,
  output logic                            res_valid_o,
  input  wire logic                       res_ready_i,
  output logic [dstf_pkg::ID_W-1:0]       res_id_o,
  output logic [dstf_pkg::DL_W-1:0]       res_dl_o,
  output logic [dstf_pkg::ST_W-1:0]       res_status_o,
  output logic [dstf_pkg::OCC_W-1:0]      res_occ_o
);
  import dstf_pkg::*;

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW:0]   DEPTH_S = (AW + 1)'(QUEUE_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  entry_t mem [QUEUE_DEPTH];
  entry_t rdata_q;
  entry_t held_q;
  entry_t wdata;

  logic [AW-1:0] head_q, head_d;
  logic [AW-1:0] tail_q, tail_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] i_q;
  logic [AW-1:0] pos_q;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic          wen;

  logic             out_valid_q;
  logic [ID_W-1:0]  out_id_q;
  logic [DL_W-1:0]  out_dl_q;
  logic [ST_W-1:0]  out_st_q;
  logic [OCC_W-1:0] out_occ_q;

  // physical slot of an offset from a base slot, circular over the store
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                            input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DEPTH_S) begin
      sum = sum - DEPTH_S;
    end
    return sum[AW-1:0];
  endfunction

  always_comb begin
    case (cmd_i.rd_sel)
      RD_HEAD:   raddr = head_q;
      RD_I:      raddr = slot_of(head_q, i_q);
      RD_I_M1:   raddr = slot_of(head_q, i_q - AW'(1));
      RD_POS_M2: raddr = slot_of(head_q, pos_q - AW'(2));
      default:   raddr = head_q;
    endcase
  end

  always_comb begin
    wen   = 1'b1;
    waddr = slot_of(head_q, pos_q);
    wdata = held_q;
    case (cmd_i.wr_sel)
      WR_TAIL: begin
        waddr = tail_q;
        wdata = '{id: enq_id_i, dl: enq_dl_i};
      end
      WR_POS_RDATA: wdata = rdata_q;
      WR_POS_HELD:  wdata = held_q;
      default:      wen = 1'b0;
    endcase
  end

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (cmd_i.push) begin
      tail_d  = slot_of(tail_q, AW'(1));
      count_d = count_q + CW'(1);
    end
    if (cmd_i.pop) begin
      head_d  = slot_of(head_q, AW'(1));
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  // insertion sort working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.i_init) begin
      i_q <= AW'(1);
    end else if (cmd_i.i_inc) begin
      i_q <= i_q + AW'(1);
    end
    if (cmd_i.hold_load) begin
      held_q <= rdata_q;
      pos_q  <= i_q;
    end else if (cmd_i.pos_dec) begin
      pos_q <= pos_q - AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res_load) begin
      out_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      out_id_q  <= cmd_i.res_data ? rdata_q.id : '0;
      out_dl_q  <= cmd_i.res_data ? rdata_q.dl : '0;
      out_st_q  <= cmd_i.res_status;
      out_occ_q <= OCC_W'(count_d);
    end
  end

  assign stat_o.cnt_zero  = (count_q == '0);
  assign stat_o.cnt_full  = (count_q == DEPTH_C);
  assign stat_o.cnt_small = (count_q <= CW'(1));
  assign stat_o.dl_gt     = (rdata_q.dl > held_q.dl);
  assign stat_o.pos_one   = (pos_q == AW'(1));
  assign stat_o.i_last    = ((CW'(i_q) + CW'(1)) == count_q);
  assign stat_o.out_free  = !out_valid_q || res_ready_i;

  assign res_valid_o  = out_valid_q;
  assign res_id_o     = out_id_q;
  assign res_dl_o     = out_dl_q;
  assign res_status_o = out_st_q;
  assign res_occ_o    = out_occ_q;

endmodule

`default_nettype wire

/* hw/rtl/deadline_sortable_task_fifo.sv */
// deadline_sortable_task_fifo: circular task fifo with a stable in-place sort by deadline
// timing: enqueue, refused ops, no-ops and sort of 0 or 1 entries: result in the cycle after
// the transfer; dequeue adds one registered memory read; one item in work at a time
// sort of n >= 2 entries: per entry after the first, fetch, hold, one compare per shifted entry
// and a final compare or place write, then done; paced by the single read and write port
// reset: async active low, empties the fifo; the entry store itself is not cleared
`timescale 1ns / 1ps
`default_nettype none

module deadline_sortable_task_fifo #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  dstf_req_if.sink    req_i,
  dstf_rsp_if.source  rsp_o
);
  import dstf_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  ready;

  dstf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_func_i  (req_i.func),
    .req_ready_o (ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  dstf_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .enq_id_i     (req_i.task_id),
    .enq_dl_i     (req_i.deadline),
    .res_valid_o  (rsp_o.valid),
    .res_ready_i  (rsp_o.ready),
    .res_id_o     (rsp_o.out_task_id),
    .res_dl_o     (rsp_o.out_deadline),
    .res_status_o (rsp_o.status),
    .res_occ_o    (rsp_o.occupancy)
  );

  assign req_i.ready = ready;

endmodule

`default_nettype wire

/* hw/rtl/dstf_checker.sv */
// dstf_checker: port-level assertions for the task fifo, bound to the top level
// depends on dstf_pkg
`timescale 1ns / 1ps
`default_nettype none

module dstf_checker #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        req_valid,
  input wire logic                        req_ready,
  input wire logic                        rsp_valid,
  input wire logic                        rsp_ready,
  input wire logic [dstf_pkg::ID_W-1:0]   rsp_id,
  input wire logic [dstf_pkg::DL_W-1:0]   rsp_dl,
  input wire logic [dstf_pkg::ST_W-1:0]   rsp_status,
  input wire logic [dstf_pkg::OCC_W-1:0]  rsp_occ
);
  import dstf_pkg::*;

  localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(QUEUE_DEPTH);

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable({rsp_id, rsp_dl, rsp_status, rsp_occ}))
    else $error("result changed while stalled");

  // no transfer in while a result is blocked
  a_no_accept_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid && req_ready |-> !rsp_valid || rsp_ready)
    else $error("request taken while result blocked");

  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && rsp_status == ST_FULL |-> rsp_occ == FULL_OCC)
    else $error("full status without full occupancy");

  a_empty_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && rsp_status == ST_EMPTY |-> rsp_occ == '0)
    else $error("empty status with entries held");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && rsp_status != ST_OK |-> rsp_id == '0 && rsp_dl == '0)
    else $error("refused operation returned an entry");

endmodule

bind deadline_sortable_task_fifo dstf_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_dstf_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .req_valid  (req_i.valid),
  .req_ready  (req_i.ready),
  .rsp_valid  (rsp_o.valid),
  .rsp_ready  (rsp_o.ready),
  .rsp_id     (rsp_o.out_task_id),
  .rsp_dl     (rsp_o.out_deadline),
  .rsp_status (rsp_o.status),
  .rsp_occ    (rsp_o.occupancy)
);

`default_nettype wire

/* tb/testbench.sv */
// testbench: self-checking bench for deadline_sortable_task_fifo, with a shadow fifo
// that predicts every result, random idling on both channels, and a final verdict
// depends on dstf_pkg, dstf_req_if / dstf_rsp_if and the fifo rtl
`timescale 1ns / 1ps

module testbench;
  import dstf_pkg::*;

  localparam int QUEUE_DEPTH = 16;
  localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;  // unused selector, block returns an ok result and changes nothing
  localparam int TOTAL_OPS   = 1050;

  typedef struct {
    logic [FUNC_W-1:0] func;
    logic [ID_W-1:0]   task_id;
    logic [DL_W-1:0]   deadline;
    bit                wait_drain;
    int unsigned       req_idle_pct;
    int unsigned       rsp_idle_pct;
  } task_op_t;

  typedef struct packed {
    logic [ID_W-1:0]  out_task_id;
    logic [DL_W-1:0]  out_deadline;
    logic [ST_W-1:0]  status;
    logic [OCC_W-1:0] occupancy;
  } fifo_rsp_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  dstf_req_if req_if ();
  dstf_rsp_if rsp_if ();

  deadline_sortable_task_fifo #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always #5 clk_i = ~clk_i;

  task_op_t    op_queue[$];
  fifo_rsp_t   result_queue[$];
  int          n_fail       = 0;
  int          req_gap      = 0;
  int          rsp_stall    = 0;
  int unsigned rsp_idle_now = 0;

  // shadow copy of the fifo contents
  entry_t shadow_store [QUEUE_DEPTH];
  int     shadow_head  = 0;
  int     shadow_tail  = 0;
  int     shadow_count = 0;

  function automatic fifo_rsp_t predict_fifo_op(input logic [FUNC_W-1:0] func,
                                                input logic [ID_W-1:0] id,
                                                input logic [DL_W-1:0] dl);
    fifo_rsp_t r;
    entry_t    work [QUEUE_DEPTH];
    entry_t    held;
    int        i;
    int        pos;
    int        slot;
    r = '0;
    case (func)
      FUNC_ENQ: begin
        if (shadow_count >= QUEUE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_store[shadow_tail] = {id, dl};
          shadow_tail = (shadow_tail + 1) % QUEUE_DEPTH;
          shadow_count++;
        end
      end
      FUNC_DEQ: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.out_task_id  = shadow_store[shadow_head].id;
          r.out_deadline = shadow_store[shadow_head].dl;
          shadow_head = (shadow_head + 1) % QUEUE_DEPTH;
          shadow_count--;
        end
      end
      FUNC_SORT: begin
        slot = shadow_head;
        for (i = 0; i < shadow_count; i++) begin
          work[i] = shadow_store[slot];
          slot = (slot + 1) % QUEUE_DEPTH;
        end
        // stable insertion sort: strict compare keeps ties in arrival order
        for (i = 1; i < shadow_count; i++) begin
          held = work[i];
          pos  = i;
          while (pos > 0 && work[pos-1].dl > held.dl) begin
            work[pos] = work[pos-1];
            pos--;
          end
          work[pos] = held;
        end
        slot = shadow_head;
        for (i = 0; i < shadow_count; i++) begin
          shadow_store[slot] = work[i];
          slot = (slot + 1) % QUEUE_DEPTH;
        end
      end
      default: ;
    endcase
    r.occupancy = shadow_count[OCC_W-1:0];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      n_fail++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  function automatic logic [ID_W-1:0] pick_id();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    return ID_W'($urandom_range(0, 65535));
  endfunction

  // mostly a narrow range so that equal deadlines are common
  function automatic logic [DL_W-1:0] pick_deadline();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return DL_W'($urandom_range(0, 7));
    if (r < 80) return DL_W'($urandom);
    if (r < 85) return '0;
    if (r < 90) return '1;
    return 32'h8000_0000 + DL_W'($urandom_range(0, 3)) - 32'd2;
  endfunction

  task automatic queue_op(input logic [FUNC_W-1:0] func, input logic [ID_W-1:0] id,
                          input logic [DL_W-1:0] dl, input bit hold);
    task_op_t op;
    int       idx;
    idx = op_queue.size();
    op.func       = func;
    op.task_id    = id;
    op.deadline   = dl;
    op.wait_drain = hold;
    // idling profile by position in the run; two stretches run without any
    if (idx < 25) begin
      op.req_idle_pct = 15; op.rsp_idle_pct = 15;
    end else if (idx < 325) begin
      op.req_idle_pct = 20; op.rsp_idle_pct = 20;
    end else if (idx < 475) begin
      op.req_idle_pct = 0;  op.rsp_idle_pct = 0;
    end else if (idx < 800) begin
      op.req_idle_pct = 40; op.rsp_idle_pct = 10;
    end else if (idx < 950) begin
      op.req_idle_pct = 5;  op.rsp_idle_pct = 50;
    end else begin
      op.req_idle_pct = 0;  op.rsp_idle_pct = 0;
    end
    op_queue.push_back(op);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : req_driver
    logic     next_valid;
    task_op_t op;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_gap = 0;
    end else begin
      next_valid = req_if.valid;
      if (req_if.valid && req_if.ready) begin
        result_queue.push_back(predict_fifo_op(req_if.func, req_if.task_id,
                                               req_if.deadline));
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (req_gap > 0) begin
          req_gap--;
        end else if (op_queue.size() != 0) begin
          if (op_queue[0].wait_drain && result_queue.size() != 0) begin
            // hold off until every outstanding result is back
          end else if ($urandom_range(0, 99) < op_queue[0].req_idle_pct) begin
            req_gap = $urandom_range(0, 14);
          end else begin
            op = op_queue.pop_front();
            req_if.func     <= op.func;
            req_if.task_id  <= op.task_id;
            req_if.deadline <= op.deadline;
            rsp_idle_now = op.rsp_idle_pct;
            next_valid = 1'b1;
          end
        end
      end
      req_if.valid <= next_valid;
      if (!next_valid) begin
        req_if.func     <= FUNC_W'($urandom);
        req_if.task_id  <= ID_W'($urandom);
        req_if.deadline <= DL_W'($urandom);
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : rsp_monitor
    fifo_rsp_t want;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      rsp_stall = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (result_queue.size() == 0) begin
          n_fail++;
          $display("%0t: unexpected result, expected none, actual id %0h dl %0h st %0d occ %0d",
                   $time, rsp_if.out_task_id, rsp_if.out_deadline, rsp_if.status,
                   rsp_if.occupancy);
        end else begin
          want = result_queue.pop_front();
          check_field("out_task_id", 32'(want.out_task_id), 32'(rsp_if.out_task_id));
          check_field("out_deadline", want.out_deadline, rsp_if.out_deadline);
          check_field("status", 32'(want.status), 32'(rsp_if.status));
          check_field("occupancy", 32'(want.occupancy), 32'(rsp_if.occupancy));
        end
      end
      if (rsp_stall > 0) begin
        rsp_stall--;
        rsp_if.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < rsp_idle_now) begin
        rsp_stall = $urandom_range(0, 14);
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  logic [DL_W-1:0] fill_deadlines [QUEUE_DEPTH] = '{
    32'd5, 32'hFFFF_FFFF, 32'd5, 32'd0, 32'd3, 32'd5, 32'h8000_0000, 32'd1,
    32'd0, 32'hFFFF_FFFE, 32'd3, 32'd7, 32'd2, 32'd5, 32'h7FFF_FFFF, 32'd1
  };

  initial begin : stimulus
    int          i;
    int          k;
    int          mode;
    int          len;
    int          fill;
    int          extra;
    int unsigned r;
    int unsigned enq_lim;
    int unsigned deq_lim;
    int unsigned sort_lim;
    bit          hold;
    bit          first;
    logic [FUNC_W-1:0] func;

    req_if.valid    = 1'b0;
    req_if.func     = FUNC_ENQ;
    req_if.task_id  = '0;
    req_if.deadline = '0;
    rsp_if.ready    = 1'b0;

    // directed: empty store cases, fill with ties and extremes, refused enqueue, no-op, sort, dequeues
    queue_op(FUNC_DEQ, '1, '1, 1'b0);
    queue_op(FUNC_SORT, '1, '1, 1'b0);
    queue_op(FUNC_NOP, '1, '1, 1'b0);
    for (i = 0; i < QUEUE_DEPTH; i++) begin
      queue_op(FUNC_ENQ, ID_W'(i * 16'h1111), fill_deadlines[i], 1'b0);
    end
    queue_op(FUNC_ENQ, 16'hBEEF, 32'd4, 1'b0);
    queue_op(FUNC_NOP, '0, '0, 1'b0);
    queue_op(FUNC_SORT, '0, '0, 1'b0);
    for (i = 0; i < 3; i++) begin
      queue_op(FUNC_DEQ, '0, '0, 1'b0);
    end

    // random episodes: biased mixes and well-formed fill / sort / drain runs
    first = 1'b1;
    while (op_queue.size() < TOTAL_OPS) begin
      mode = $urandom_range(0, 3);
      hold = first || ($urandom_range(0, 9) == 0);
      first = 1'b0;
      if (mode == 3) begin
        fill  = $urandom_range(1, QUEUE_DEPTH + 2);
        extra = $urandom_range(0, 3);
        for (k = 0; k < fill; k++) begin
          queue_op(FUNC_ENQ, pick_id(), pick_deadline(), hold && k == 0);
        end
        queue_op(FUNC_SORT, pick_id(), pick_deadline(), 1'b0);
        for (k = 0; k < extra; k++) begin
          queue_op(FUNC_ENQ, pick_id(), pick_deadline(), 1'b0);
        end
        for (k = 0; k < fill + extra + 1; k++) begin
          queue_op(FUNC_DEQ, pick_id(), pick_deadline(), 1'b0);
        end
      end else begin
        case (mode)
          0:       begin enq_lim = 65; deq_lim = 82; sort_lim = 96; end
          1:       begin enq_lim = 20; deq_lim = 85; sort_lim = 96; end
          default: begin enq_lim = 45; deq_lim = 85; sort_lim = 97; end
        endcase
        len = $urandom_range(4, 40);
        for (k = 0; k < len; k++) begin
          r = $urandom_range(0, 99);
          if (r < enq_lim) func = FUNC_ENQ;
          else if (r < deq_lim) func = FUNC_DEQ;
          else if (r < sort_lim) func = FUNC_SORT;
          else func = FUNC_NOP;
          queue_op(func, pick_id(), pick_deadline(), hold && k == 0);
        end
      end
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // sample at the falling edge so every rising-edge update has settled
    while (op_queue.size() != 0 || req_if.valid || result_queue.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (20) @(posedge clk_i);

    if (n_fail == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

/* deadline_sortable_task_fifo.f */
hw/rtl/dstf_pkg.sv
hw/rtl/dstf_if.sv
hw/rtl/dstf_ctrl.sv
hw/rtl/dstf_datapath.sv
hw/rtl/deadline_sortable_task_fifo.sv
hw/rtl/dstf_checker.sv
tb/testbench.sv
